// ===== design/cswc_pkg.sv =====
// ----------------------------------------------------------------------------
// cswc_pkg: shared definitions for the constant-stiffness wall controller
// Fixed-point widths, saturation helpers, register codes and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cswc_pkg;

  // Field widths.
  localparam int DATA_W     = 48;
  localparam int FRAC_BITS  = 16;
  localparam int BODY_W     = 16;
  localparam int ID_BITS    = 16;
  localparam int STIFF_W    = 47;
  localparam int UNLOAD_W   = 21;
  localparam int DAMP_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 47;

  // Shared multiplier: magnitude times one digit of the other magnitude per cycle.
  localparam int PROD_W      = 2 * DATA_W;
  localparam int MUL_DIGIT_W = 16;
  localparam int MUL_DIGITS  = DATA_W / MUL_DIGIT_W;
  localparam int MUL_CNT_W   = $clog2(MUL_DIGITS + 2);
  localparam int PP_W        = DATA_W + MUL_DIGIT_W;

  // Restoring divider: one quotient bit per cycle over the shifted dividend.
  localparam int DVD_W     = DATA_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  typedef logic signed [DATA_W-1:0] fix_t;
  typedef logic [DATA_W-1:0]        mag_t;

  localparam logic [MUL_CNT_W-1:0] MUL_LAST   = MUL_CNT_W'(MUL_DIGITS + 1);
  localparam logic [MUL_CNT_W-1:0] MUL_DIGS_C = MUL_CNT_W'(MUL_DIGITS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST   = DIV_CNT_W'(DVD_W);

  localparam fix_t FIX_MAX = fix_t'({1'b0, {(DATA_W-1){1'b1}}});
  localparam fix_t FIX_MIN = fix_t'({1'b1, {(DATA_W-1){1'b0}}});
  localparam mag_t MAG_LIM = mag_t'({1'b1, {(DATA_W-1){1'b0}}});
  localparam fix_t FIX_ONE = fix_t'(mag_t'(1) << FRAC_BITS);

  // Register reset values.
  localparam logic [STIFF_W-1:0]  WALL_STIFF_RST = '0;
  localparam logic [UNLOAD_W-1:0] UNLOAD_RST     = UNLOAD_W'(1) << FRAC_BITS;
  localparam logic [DAMP_W-1:0]   DAMP_RST       = '0;
  localparam logic [STIFF_W-1:0]  MAX_STEP_RST   = STIFF_W'(1) << FRAC_BITS;
  localparam logic [BODY_W-1:0]   TOP_ID_RST     = BODY_W'(3);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WALL_STIFFNESS  = 3'd0,
    REG_UNLOAD_FACTOR   = 3'd1,
    REG_DAMPING         = 3'd2,
    REG_MAX_HEIGHT_STEP = 3'd3,
    REG_TOP_WALL_ID     = 3'd4
  } cfg_reg_t;

  // Which product the shared multiplier forms.
  typedef enum logic [2:0] {
    MO_AREA,
    MO_KW,
    MO_TGT,
    MO_KS,
    MO_DAMP
  } mul_op_t;

  typedef struct packed {
    logic                      operation;
    logic [BODY_W-1:0]         body_a;
    logic [BODY_W-1:0]         body_b;
    logic [STIFF_W-1:0]        contact_stiffness;
    logic                      contact_loaded;
    fix_t                      top_force;
    fix_t                      top_height;
    fix_t                      left_edge;
    fix_t                      right_edge;
    fix_t                      front_edge;
    fix_t                      back_edge;
  } item_t;

  typedef struct packed {
    fix_t height_step;
    logic unloading;
    logic step_clamped;
    logic zero_divisor;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic    acc_en;
    logic    cap_en;
    logic    prep;
    logic    mul_start;
    mul_op_t mul_op;
    logic    den_en;
    logic    div_start;
    logic    out_load;
    logic    zdiv;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic unl;
    logic den_zero;
    logic out_free;
  } dp_stat_t;

  // Magnitude of a two's complement value; the most negative value maps to 2^47.
  function automatic mag_t magn(input fix_t x);
    mag_t ux;
    ux = mag_t'(x);
    return ux[DATA_W-1] ? (~ux + mag_t'(1)) : ux;
  endfunction

  // Applies a sign to a magnitude and saturates; over marks a magnitude already too big.
  function automatic fix_t sat_sm(input logic neg, input logic over, input mag_t m);
    if (neg) begin
      if (over || (m > MAG_LIM)) return FIX_MIN;
      return fix_t'(~m + mag_t'(1));
    end
    if (over || m[DATA_W-1]) return FIX_MAX;
    return fix_t'(m);
  endfunction

  function automatic fix_t sat_add(input fix_t a, input fix_t b);
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? FIX_MIN : FIX_MAX;
    return fix_t'(s[DATA_W-1:0]);
  endfunction

  function automatic fix_t sat_sub(input fix_t a, input fix_t b);
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? FIX_MIN : FIX_MAX;
    return fix_t'(s[DATA_W-1:0]);
  endfunction

endpackage

`default_nettype wire

// ===== design/cswc_item_if.sv =====
// ----------------------------------------------------------------------------
// cswc_item_if: input item channel
// Valid/ready channel carrying one contact or control-step item per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface cswc_item_if import cswc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [BODY_W-1:0]    body_a;
  logic [BODY_W-1:0]    body_b;
  logic [STIFF_W-1:0]   contact_stiffness;
  logic                 contact_loaded;
  logic signed [DATA_W-1:0] top_force;
  logic signed [DATA_W-1:0] top_height;
  logic signed [DATA_W-1:0] left_edge;
  logic signed [DATA_W-1:0] right_edge;
  logic signed [DATA_W-1:0] front_edge;
  logic signed [DATA_W-1:0] back_edge;

  modport source (
    output valid, operation, body_a, body_b, contact_stiffness, contact_loaded,
    output top_force, top_height, left_edge, right_edge, front_edge, back_edge,
    input  ready
  );

  modport sink (
    input  valid, operation, body_a, body_b, contact_stiffness, contact_loaded,
    input  top_force, top_height, left_edge, right_edge, front_edge, back_edge,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/cswc_result_if.sv =====
// ----------------------------------------------------------------------------
// cswc_result_if: result channel
// Valid/ready channel carrying one height step result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface cswc_result_if import cswc_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] height_step;
  logic                     unloading;
  logic                     step_clamped;
  logic                     zero_divisor;

  modport source (
    output valid, height_step, unloading, step_clamped, zero_divisor,
    input  ready
  );

  modport sink (
    input  valid, height_step, unloading, step_clamped, zero_divisor,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/cswc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// cswc_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface cswc_cfg_if import cswc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/cswc_mul.sv =====
// ----------------------------------------------------------------------------
// cswc_mul: sequential saturating fixed-point multiplier
// Sign-magnitude product built one 16-bit digit per cycle, shifted down by
// the fraction width and saturated to the signed data range.
// ----------------------------------------------------------------------------
`default_nettype none

module cswc_mul import cswc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  fix_t a,
  input  fix_t b,
  output logic done,
  output fix_t res
);

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  mag_t                 ua;
  mag_t                 ub_sh;
  logic                 neg;
  logic [PP_W-1:0]      pp;
  logic [PROD_W-1:0]    acc;

  // Sequencing: one digit product per cycle, then a final saturation step.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == MUL_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + MUL_CNT_W'(1);
      end
    end
  end

  // Digit products are registered before they enter the accumulator.
  always_ff @(posedge clk) begin
    if (start) begin
      ua    <= magn(a);
      ub_sh <= magn(b);
      neg   <= a[DATA_W-1] ^ b[DATA_W-1];
      acc   <= '0;
    end else if (busy) begin
      if (cnt < MUL_DIGS_C) begin
        pp    <= ua * ub_sh[DATA_W-1 -: MUL_DIGIT_W];
        ub_sh <= ub_sh << MUL_DIGIT_W;
      end
      if ((cnt != '0) && (cnt <= MUL_DIGS_C)) begin
        acc <= (acc << MUL_DIGIT_W) + PROD_W'(pp);
      end
      if (cnt == MUL_LAST) begin
        res <= sat_sm(neg, |acc[PROD_W-1:FRAC_BITS+DATA_W], acc[FRAC_BITS +: DATA_W]);
      end
    end
  end

`ifndef NO_ASSERTIONS
  // No new operation is started while one is in flight.
  a_no_restart: assert property (@(posedge clk) disable iff (rst) busy |-> !start)
    else $error("multiplier restarted while busy");
`endif

endmodule

`default_nettype wire

// ===== design/cswc_div.sv =====
// ----------------------------------------------------------------------------
// cswc_div: sequential saturating fixed-point divider
// Restoring division of the magnitudes, one quotient bit per cycle, with the
// dividend pre-shifted by the fraction width and the result saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module cswc_div import cswc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  fix_t num,
  input  fix_t den,
  output logic done,
  output fix_t res
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVD_W-1:0]     dvd;
  logic [DVD_W-1:0]     q;
  mag_t                 ud;
  mag_t                 rem;
  logic                 neg;
  logic [DATA_W:0]      trial;
  logic                 qb;

  // Trial subtraction of the partial remainder.
  assign trial = {rem, dvd[DVD_W-1]};
  assign qb    = trial >= {1'b0, ud};

  // Sequencing: one bit per cycle, then a final saturation step.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == DIV_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + DIV_CNT_W'(1);
      end
    end
  end

  // Remainder, quotient and dividend shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {magn(num), FRAC_BITS'(0)};
      ud  <= magn(den);
      rem <= '0;
      q   <= '0;
      neg <= num[DATA_W-1] ^ den[DATA_W-1];
    end else if (busy) begin
      if (cnt != DIV_LAST) begin
        rem <= qb ? DATA_W'(trial - {1'b0, ud}) : trial[DATA_W-1:0];
        q   <= {q[DVD_W-2:0], qb};
        dvd <= dvd << 1;
      end else begin
        res <= sat_sm(neg, |q[DVD_W-1:DATA_W], q[DATA_W-1:0]);
      end
    end
  end

`ifndef NO_ASSERTIONS
  // The partial remainder always stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (busy && $past(busy) && !$past(start)) |-> (rem < ud))
    else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire

// ===== design/cswc_dp.sv =====
// ----------------------------------------------------------------------------
// cswc_dp: datapath of the constant-stiffness wall controller
// Configuration registers, stiffness accumulator, reference latch, working
// registers around the shared multiplier and divider, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cswc_dp import cswc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              st,
  input  item_t                 item,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output result_t               out_data
);

  logic [STIFF_W-1:0]  wall_stiffness;
  logic [UNLOAD_W-1:0] unload_factor;
  logic [DAMP_W-1:0]   damping;
  logic [STIFF_W-1:0]  max_height_step;
  logic [BODY_W-1:0]   top_wall_id;

  mag_t stiffness_sum;
  logic first_done;
  fix_t ref_force;
  fix_t ref_height;

  fix_t force_r, height_r, left_r, right_r, front_r, back_r;
  fix_t width, depth, dh, area, kw, target, ks, denom, num, step;

  fix_t mul_a, mul_b, mul_res, div_res;
  logic mul_done, div_done;

  logic hit;
  mag_t sum_add;
  logic unl;
  mag_t step_mag;
  mag_t max_mag;
  logic over;
  fix_t clamp_val;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      wall_stiffness  <= WALL_STIFF_RST;
      unload_factor   <= UNLOAD_RST;
      damping         <= DAMP_RST;
      max_height_step <= MAX_STEP_RST;
      top_wall_id     <= TOP_ID_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WALL_STIFFNESS:  wall_stiffness  <= cfg_data;
        REG_UNLOAD_FACTOR:   unload_factor   <= cfg_data[UNLOAD_W-1:0];
        REG_DAMPING:         damping         <= cfg_data[DAMP_W-1:0];
        REG_MAX_HEIGHT_STEP: max_height_step <= cfg_data;
        REG_TOP_WALL_ID:     top_wall_id     <= cfg_data[BODY_W-1:0];
        default: ;
      endcase
    end
  end

  // Contact on the top wall: saturating stiffness accumulation.
  assign hit = item.contact_loaded &&
               ((item.body_a[ID_BITS-1:0] == top_wall_id[ID_BITS-1:0]) ||
                (item.body_b[ID_BITS-1:0] == top_wall_id[ID_BITS-1:0]));
  assign sum_add = stiffness_sum + DATA_W'(item.contact_stiffness);

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness_sum <= '0;
    end else if (cmd.out_load) begin
      stiffness_sum <= '0;
    end else if (cmd.acc_en && hit) begin
      stiffness_sum <= sum_add[DATA_W-1] ? mag_t'(FIX_MAX) : sum_add;
    end
  end

  // The first control step latches the reference force and height.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_done <= 1'b0;
      ref_force  <= '0;
      ref_height <= '0;
    end else if (cmd.cap_en && !first_done) begin
      first_done <= 1'b1;
      ref_force  <= item.top_force;
      ref_height <= item.top_height;
    end
  end

  // Capture of the control-step fields.
  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      force_r  <= item.top_force;
      height_r <= item.top_height;
      left_r   <= item.left_edge;
      right_r  <= item.right_edge;
      front_r  <= item.front_edge;
      back_r   <= item.back_edge;
    end
  end

  // Force error sign decides whether the unload factor applies.
  assign unl = force_r > target;

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (cmd.mul_op)
      MO_AREA: begin
        mul_a = width;
        mul_b = depth;
      end
      MO_KW: begin
        mul_a = fix_t'(DATA_W'(wall_stiffness));
        mul_b = area;
      end
      MO_TGT: begin
        mul_a = kw;
        mul_b = dh;
      end
      MO_KS: begin
        mul_a = fix_t'(stiffness_sum);
        mul_b = fix_t'(DATA_W'(unload_factor));
      end
      MO_DAMP: begin
        mul_a = div_res;
        mul_b = FIX_ONE - fix_t'(DATA_W'(damping));
      end
      default: begin
        mul_a = width;
        mul_b = depth;
      end
    endcase
  end

  cswc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  cswc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (denom),
    .done  (div_done),
    .res   (div_res)
  );

  // Working registers of the control step.
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      width <= sat_sub(right_r, left_r);
      depth <= sat_sub(front_r, back_r);
      dh    <= sat_sub(height_r, ref_height);
    end
    if (mul_done) begin
      unique case (cmd.mul_op)
        MO_AREA: area   <= mul_res;
        MO_KW:   kw     <= mul_res;
        MO_TGT:  target <= sat_add(ref_force, mul_res);
        MO_KS:   ks     <= mul_res;
        MO_DAMP: step   <= mul_res;
        default: ;
      endcase
    end
    if (cmd.den_en) begin
      denom <= sat_add(unl ? ks : fix_t'(stiffness_sum), kw);
      num   <= sat_sub(force_r, target);
    end
  end

  // Clamp of the damped step to the largest allowed magnitude.
  assign step_mag  = magn(step);
  assign max_mag   = DATA_W'(max_height_step);
  assign over      = step_mag > max_mag;
  assign clamp_val = step[DATA_W-1] ? fix_t'(~max_mag + mag_t'(1)) : fix_t'(max_mag);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.height_step  <= cmd.zdiv ? '0 : (over ? clamp_val : step);
      out_data.unloading    <= unl;
      out_data.step_clamped <= !cmd.zdiv && over;
      out_data.zero_divisor <= cmd.zdiv;
    end
  end

  // Status to the controller.
  always_comb begin
    st.mul_done = mul_done;
    st.div_done = div_done;
    st.unl      = unl;
    st.den_zero = (denom == '0);
    st.out_free = !out_valid || out_ready;
  end

`ifndef NO_ASSERTIONS
  // The stiffness sum never leaves the non-negative range.
  a_sum_range: assert property (@(posedge clk) disable iff (rst) !stiffness_sum[DATA_W-1])
    else $error("stiffness sum out of range");
  // A loaded result is offered in the next cycle.
  a_load_valid: assert property (@(posedge clk) disable iff (rst) cmd.out_load |=> out_valid)
    else $error("loaded result not offered");
`endif

endmodule

`default_nettype wire

// ===== design/cswc_ctrl.sv =====
// ----------------------------------------------------------------------------
// cswc_ctrl: controller of the constant-stiffness wall controller
// Takes contact items one per cycle while no control step is in flight, and walks a control step through the
// shared multiplier and divider, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cswc_ctrl import cswc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      operation,
  output logic      in_ready,
  input  dp_stat_t  st,
  output ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_CMP,
    S_DEN,
    S_CHK,
    S_DIV,
    S_WAIT,
    S_LOAD
  } state_t;

  state_t    state;
  logic      ready;
  ctrl_cmd_t cmd_r;
  logic      accept;

  assign in_ready = ready;
  assign accept   = in_valid && ready;

  // Accept strobes go straight out; everything else is registered.
  always_comb begin
    cmd        = cmd_r;
    cmd.acc_en = accept && !operation;
    cmd.cap_en = accept && operation;
  end

  // State and registered commands.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ready <= 1'b1;
      cmd_r <= '0;
    end else begin
      cmd_r.prep      <= 1'b0;
      cmd_r.mul_start <= 1'b0;
      cmd_r.den_en    <= 1'b0;
      cmd_r.div_start <= 1'b0;
      cmd_r.out_load  <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && operation) begin
            state      <= S_PREP;
            ready      <= 1'b0;
            cmd_r.prep <= 1'b1;
            cmd_r.zdiv <= 1'b0;
          end
        end
        S_PREP: begin
          state           <= S_MUL;
          cmd_r.mul_start <= 1'b1;
          cmd_r.mul_op    <= MO_AREA;
        end
        S_MUL: begin
          if (st.mul_done) begin
            unique case (cmd_r.mul_op)
              MO_AREA: begin
                cmd_r.mul_start <= 1'b1;
                cmd_r.mul_op    <= MO_KW;
              end
              MO_KW: begin
                cmd_r.mul_start <= 1'b1;
                cmd_r.mul_op    <= MO_TGT;
              end
              MO_TGT:  state <= S_CMP;
              MO_KS: begin
                state        <= S_DEN;
                cmd_r.den_en <= 1'b1;
              end
              MO_DAMP: state <= S_WAIT;
              default: state <= S_WAIT;
            endcase
          end
        end
        S_CMP: begin
          if (st.unl) begin
            state           <= S_MUL;
            cmd_r.mul_start <= 1'b1;
            cmd_r.mul_op    <= MO_KS;
          end else begin
            state        <= S_DEN;
            cmd_r.den_en <= 1'b1;
          end
        end
        S_DEN: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (st.den_zero) begin
            state      <= S_WAIT;
            cmd_r.zdiv <= 1'b1;
          end else begin
            state           <= S_DIV;
            cmd_r.div_start <= 1'b1;
          end
        end
        S_DIV: begin
          if (st.div_done) begin
            state           <= S_MUL;
            cmd_r.mul_start <= 1'b1;
            cmd_r.mul_op    <= MO_DAMP;
          end
        end
        S_WAIT: begin
          if (st.out_free) begin
            state          <= S_LOAD;
            cmd_r.out_load <= 1'b1;
          end
        end
        S_LOAD: begin
          state <= S_IDLE;
          ready <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          ready <= 1'b1;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // Unit completions only arrive while the sequence waits for them.
  a_mul_done: assert property (@(posedge clk) disable iff (rst) st.mul_done |-> state == S_MUL)
    else $error("multiplier done outside multiply state");
  a_div_done: assert property (@(posedge clk) disable iff (rst) st.div_done |-> state == S_DIV)
    else $error("divider done outside divide state");
  // A result is only loaded into a free output register.
  a_out_free: assert property (@(posedge clk) disable iff (rst) cmd.out_load |-> st.out_free)
    else $error("output register overwritten");
  // A control step starts its sequence right after acceptance.
  a_step_go: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && operation) |=> (state == S_PREP && !in_ready))
    else $error("control step not started");
`endif

endmodule

`default_nettype wire

// ===== design/constant_stiffness_wall_controller.sv =====
// Contact items: one per cycle while no control step is in progress, no result; the
// running sum updates in the accepting cycle. Control step: four passes through the
// digit-serial multiplier, five when unloading, and one pass through the bit-serial divider
// (with a zero divisor, three or four multiplier passes and no divider pass).
// The next item is accepted in the cycle after the result is loaded; a waiting result does
// not block it. Synchronous active-high reset restores register defaults and clears state.
// ----------------------------------------------------------------------------
// constant_stiffness_wall_controller: top level
// Joins the item, result and configuration channels to the controller and
// the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module constant_stiffness_wall_controller import cswc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  cswc_item_if.sink     item,
  cswc_result_if.source result,
  cswc_cfg_if.sink      cfg
);

  item_t     item_d;
  result_t   out_data;
  logic      out_valid;
  logic      in_ready;
  ctrl_cmd_t cmd;
  dp_stat_t  st;

  // Pack the item beat.
  always_comb begin
    item_d.operation         = item.operation;
    item_d.body_a            = item.body_a;
    item_d.body_b            = item.body_b;
    item_d.contact_stiffness = item.contact_stiffness;
    item_d.contact_loaded    = item.contact_loaded;
    item_d.top_force         = item.top_force;
    item_d.top_height        = item.top_height;
    item_d.left_edge         = item.left_edge;
    item_d.right_edge        = item.right_edge;
    item_d.front_edge        = item.front_edge;
    item_d.back_edge         = item.back_edge;
  end

  // Handshakes and result beat.
  assign item.ready          = in_ready;
  assign cfg.ready           = 1'b1;
  assign result.valid        = out_valid;
  assign result.height_step  = out_data.height_step;
  assign result.unloading    = out_data.unloading;
  assign result.step_clamped = out_data.step_clamped;
  assign result.zero_divisor = out_data.zero_divisor;

  cswc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .operation (item.operation),
    .in_ready  (in_ready),
    .st        (st),
    .cmd       (cmd)
  );

  cswc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .item      (item_d),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .out_ready (result.ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
